// ----- hdl/mnhr_pkg.sv -----
// shared types and constants for the mesh next-hop router
// no dependencies; used by every module of the block
package mnhr_pkg;

   localparam int NEIGHBOR_SLOTS = 16;
   localparam int SLOT_IDX_W     = (NEIGHBOR_SLOTS > 1) ? $clog2(NEIGHBOR_SLOTS) : 1;
   localparam int RESULT_CAP     = 16;
   localparam int CNT_W          = $clog2(RESULT_CAP);
   localparam int QUEUE_DEPTH    = 2;
   localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int MAC_W          = 48;
   localparam int CSR_IDX_W      = 4;

   localparam logic [7:0]       NO_ROUTE  = 8'hFF;
   localparam logic [MAC_W-1:0] MAC_ONES  = '1;
   localparam logic [15:0]      BCAST_TOP = 16'hFFFF;

   localparam logic [2:0] STAT_OK        = 3'd0;
   localparam logic [2:0] STAT_HOP_LIMIT = 3'd1;
   localparam logic [2:0] STAT_NO_MASTER = 3'd2;
   localparam logic [2:0] STAT_NO_TARGET = 3'd3;
   localparam logic [2:0] STAT_BAD_TGT   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_OWN_ADDR    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MASTER_ADDR = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MASTER_VIA  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MASTER_HOPS = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_HOP_LIMIT   = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BEACON_CODE = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_ADAPTER_CODE = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SERIAL_CODE = 4'd7;

   typedef enum logic [1:0] {
      CMD_WRITE,
      CMD_SINGLE,
      CMD_BCAST,
      CMD_TARGET
   } cmd_type;

   typedef struct packed {
      logic [MAC_W-1:0] own_address;
      logic [MAC_W-1:0] master_address;
      logic [MAC_W-1:0] master_via;
      logic [7:0]       master_hops;
      logic [7:0]       hop_limit;
      logic [7:0]       beacon_type_code;
      logic [7:0]       adapter_data_code;
      logic [7:0]       serial_payload_code;
   } cfg_type;

   // addr holds the entry mac, the result mac, the origin or the target by command
   typedef struct packed {
      cmd_type          cmd;
      logic [2:0]       status;
      logic             present;
      logic [MAC_W-1:0] addr;
      logic [7:0]       hop_dist;
      logic [3:0]       slot;
      logic             used;
   } q_entry_type;

endpackage

// ----- hdl/mnhr_front.sv -----
// front end: accepts request beats and classifies them into queue commands
// depends on mnhr_pkg
module mnhr_front (
   input  logic                      start,
   output logic                      busy,
   input  logic                      q_full,
   output logic                      q_push,
   output mnhr_pkg::q_entry_type     q_data,
   input  mnhr_pkg::cfg_type         cfg,
   input  logic                      req_opcode,
   input  logic [7:0]                req_hop_count,
   input  logic [7:0]                req_msg_kind,
   input  logic [7:0]                req_payload_kind,
   input  logic [mnhr_pkg::MAC_W-1:0] req_origin_address,
   input  logic [mnhr_pkg::MAC_W-1:0] req_target_address,
   input  logic [3:0]                req_entry_slot,
   input  logic [mnhr_pkg::MAC_W-1:0] req_entry_address,
   input  logic                      req_entry_used
);

   logic is_bcast;
   logic master_ok;

   assign busy   = q_full;
   assign q_push = start && !q_full;

   assign is_bcast = (req_msg_kind == cfg.beacon_type_code)
                  || (req_payload_kind == cfg.serial_payload_code)
                  || (req_target_address[47:32] == mnhr_pkg::BCAST_TOP);
   assign master_ok = (cfg.master_hops != mnhr_pkg::NO_ROUTE)
                   && (cfg.master_address != cfg.own_address);

   always_comb begin
      q_data         = '0;
      q_data.slot    = req_entry_slot;
      q_data.used    = req_entry_used;
      q_data.cmd     = mnhr_pkg::CMD_SINGLE;
      q_data.status  = mnhr_pkg::STAT_OK;
      if (req_opcode) begin
         q_data.cmd  = mnhr_pkg::CMD_WRITE;
         q_data.addr = req_entry_address;
      end else if (req_hop_count >= cfg.hop_limit) begin
         q_data.status = mnhr_pkg::STAT_HOP_LIMIT;
      end else if (is_bcast) begin
         q_data.cmd  = mnhr_pkg::CMD_BCAST;
         q_data.addr = req_origin_address;
      end else if (req_msg_kind == cfg.adapter_data_code) begin
         if (master_ok) begin
            q_data.present  = 1'b1;
            q_data.addr     = cfg.master_via;
            q_data.hop_dist = cfg.master_hops;
         end else begin
            q_data.status = mnhr_pkg::STAT_NO_MASTER;
         end
      end else if ((req_target_address == '0)
                || (req_target_address == mnhr_pkg::MAC_ONES)) begin
         q_data.status = mnhr_pkg::STAT_BAD_TGT;
      end else begin
         q_data.cmd  = mnhr_pkg::CMD_TARGET;
         q_data.addr = req_target_address;
      end
   end

endmodule

// ----- hdl/mnhr_queue.sv -----
// small fifo of classified commands between front and back
// depends on mnhr_pkg
module mnhr_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mnhr_pkg::q_entry_type push_data,
   input  logic                  pop,
   output mnhr_pkg::q_entry_type head,
   output logic                  empty,
   output logic                  full
);

   mnhr_pkg::q_entry_type        store_ff [mnhr_pkg::QUEUE_DEPTH];
   logic [mnhr_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [mnhr_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [mnhr_pkg::QPTR_W:0]    count_ff, count_in;

   function automatic logic [mnhr_pkg::QPTR_W-1:0] bump(input logic [mnhr_pkg::QPTR_W-1:0] p);
      if (p == mnhr_pkg::QPTR_W'(mnhr_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (mnhr_pkg::QPTR_W + 1)'(mnhr_pkg::QUEUE_DEPTH));
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- hdl/mnhr_back.sv -----
// back end: neighbor table, table lookups and result sequencing
// depends on mnhr_pkg
module mnhr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  mnhr_pkg::cfg_type          cfg,
   input  logic                       q_empty,
   input  mnhr_pkg::q_entry_type      head,
   output logic                       q_pop,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_hop_present,
   output logic [mnhr_pkg::MAC_W-1:0] rsp_next_address,
   output logic [7:0]                 rsp_distance,
   output logic                       rsp_final_res
);

   typedef enum logic {
      ST_IDLE,
      ST_BCAST
   } state_type;

   state_type                        state_ff, state_in;
   logic [mnhr_pkg::NEIGHBOR_SLOTS-1:0] mask_ff, mask_in;
   logic [mnhr_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic                             valid_ff, valid_in;
   logic [2:0]                       status_ff, status_in;
   logic                             present_ff, present_in;
   logic [mnhr_pkg::MAC_W-1:0]       addr_ff, addr_in;
   logic [7:0]                       dist_ff, dist_in;
   logic                             final_ff, final_in;

   logic [mnhr_pkg::MAC_W-1:0]       nbr_addr_ff [mnhr_pkg::NEIGHBOR_SLOTS];
   logic [mnhr_pkg::NEIGHBOR_SLOTS-1:0] nbr_present_ff;

   logic [mnhr_pkg::NEIGHBOR_SLOTS-1:0] elig;
   logic [mnhr_pkg::NEIGHBOR_SLOTS-1:0] rest;
   logic [mnhr_pkg::SLOT_IDX_W-1:0]  sel;
   logic                             peer_hit;
   logic                             route_ok;
   logic                             tbl_we;
   logic                             slot_ok;
   logic [mnhr_pkg::SLOT_IDX_W-1:0]  wr_idx;

   assign q_pop = (state_ff == ST_IDLE) && !q_empty;
   assign slot_ok = (32'(head.slot) < mnhr_pkg::NEIGHBOR_SLOTS);
   assign wr_idx = mnhr_pkg::SLOT_IDX_W'(head.slot);
   assign route_ok = (cfg.master_hops != mnhr_pkg::NO_ROUTE);
   assign rest = mask_ff & (mask_ff - 1'b1);

   always_comb begin
      elig     = '0;
      peer_hit = 1'b0;
      for (int i = 0; i < mnhr_pkg::NEIGHBOR_SLOTS; i++) begin
         elig[i] = nbr_present_ff[i] && (nbr_addr_ff[i] != cfg.own_address)
                && (nbr_addr_ff[i] != head.addr);
         if (nbr_present_ff[i] && (nbr_addr_ff[i] == head.addr)) begin
            peer_hit = 1'b1;
         end
      end
   end

   // lowest pending slot
   always_comb begin
      sel = '0;
      for (int i = mnhr_pkg::NEIGHBOR_SLOTS - 1; i >= 0; i--) begin
         if (mask_ff[i]) begin
            sel = mnhr_pkg::SLOT_IDX_W'(i);
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      mask_in    = mask_ff;
      cnt_in     = cnt_ff;
      valid_in   = 1'b0;
      status_in  = status_ff;
      present_in = present_ff;
      addr_in    = addr_ff;
      dist_in    = dist_ff;
      final_in   = final_ff;
      tbl_we     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (head.cmd)
                  mnhr_pkg::CMD_WRITE: begin
                     tbl_we = slot_ok;
                  end
                  mnhr_pkg::CMD_SINGLE: begin
                     valid_in   = 1'b1;
                     status_in  = head.status;
                     present_in = head.present;
                     addr_in    = head.addr;
                     dist_in    = head.hop_dist;
                     final_in   = 1'b1;
                  end
                  mnhr_pkg::CMD_TARGET: begin
                     valid_in = 1'b1;
                     final_in = 1'b1;
                     if (head.addr == cfg.master_address) begin
                        present_in = route_ok;
                        addr_in    = cfg.master_via;
                     end else if (peer_hit) begin
                        present_in = 1'b1;
                        addr_in    = head.addr;
                     end else begin
                        present_in = route_ok;
                        addr_in    = cfg.master_via;
                     end
                     if (head.addr == cfg.own_address) begin
                        dist_in = 8'd0;
                     end else if (peer_hit) begin
                        dist_in = 8'd1;
                     end else begin
                        dist_in = 8'd2;
                     end
                     status_in = mnhr_pkg::STAT_OK;
                     if (!present_in) begin
                        status_in = mnhr_pkg::STAT_NO_TARGET;
                        addr_in   = '0;
                        dist_in   = 8'd0;
                     end
                  end
                  mnhr_pkg::CMD_BCAST: begin
                     if (elig == '0) begin
                        valid_in   = 1'b1;
                        status_in  = mnhr_pkg::STAT_OK;
                        present_in = 1'b0;
                        addr_in    = '0;
                        dist_in    = 8'd1;
                        final_in   = 1'b1;
                     end else begin
                        mask_in  = elig;
                        cnt_in   = '0;
                        state_in = ST_BCAST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BCAST: begin
            valid_in   = 1'b1;
            status_in  = mnhr_pkg::STAT_OK;
            present_in = 1'b1;
            addr_in    = nbr_addr_ff[sel];
            dist_in    = 8'd1;
            final_in   = (rest == '0) || (cnt_ff == mnhr_pkg::CNT_W'(mnhr_pkg::RESULT_CAP - 1));
            mask_in    = rest;
            cnt_in     = cnt_ff + 1'b1;
            if (final_in) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      mask_ff    <= mask_in;
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      present_ff <= present_in;
      addr_ff    <= addr_in;
      dist_ff    <= dist_in;
      final_ff   <= final_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nbr_present_ff <= '0;
      end else if (tbl_we) begin
         nbr_present_ff[wr_idx] <= head.used;
      end
      if (tbl_we) begin
         nbr_addr_ff[wr_idx] <= head.addr;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_hop_present  = present_ff;
   assign rsp_next_address = addr_ff;
   assign rsp_distance     = dist_ff;
   assign rsp_final_res    = final_ff;

endmodule

// ----- hdl/mesh_next_hop_router_core.sv -----
// top level of the mesh next-hop router: config registers, front, queue, back
// depends on mnhr_pkg, mnhr_front, mnhr_queue, mnhr_back
//
// A request beat is taken whenever start is high and busy is low; the front classifies
// it into a two-entry command queue, so busy rises only when that queue is full. The back
// end drains one command per cycle while it is not sending broadcast hops: a table write
// gives no result, a hop-limit, adapter, error or directed message gives one result, and
// a broadcast scans the 16-slot neighbor table and then gives one result per eligible
// neighbor (up to 16 results). A single result, or a broadcast with no eligible neighbor,
// appears as a one-cycle rsp_valid strobe in the cycle after its command leaves the queue;
// broadcast hops follow one per cycle from the broadcast state that the scan enters. All
// results come in request order, with rsp_final_res on the last result of each message; the
// receiver has no way to stall them. The user must write config registers
// through csr_valid/csr_ready only while the block is idle; the block does not enforce it.
module mesh_next_hop_router_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic                       req_opcode,
   input  logic [7:0]                 req_hop_count,
   input  logic [7:0]                 req_msg_kind,
   input  logic [7:0]                 req_payload_kind,
   input  logic [mnhr_pkg::MAC_W-1:0] req_origin_address,
   input  logic [mnhr_pkg::MAC_W-1:0] req_target_address,
   input  logic [3:0]                 req_entry_slot,
   input  logic [mnhr_pkg::MAC_W-1:0] req_entry_address,
   input  logic                       req_entry_used,
   output logic                       rsp_valid,
   output logic [2:0]                 rsp_status,
   output logic                       rsp_hop_present,
   output logic [mnhr_pkg::MAC_W-1:0] rsp_next_address,
   output logic [7:0]                 rsp_distance,
   output logic                       rsp_final_res,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [mnhr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mnhr_pkg::MAC_W-1:0] csr_data
);

   mnhr_pkg::cfg_type     cfg_ff, cfg_in;
   mnhr_pkg::q_entry_type push_data;
   mnhr_pkg::q_entry_type head;
   logic                  q_push;
   logic                  q_pop;
   logic                  q_empty;
   logic                  q_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mnhr_pkg::REG_OWN_ADDR:     cfg_in.own_address         = csr_data;
            mnhr_pkg::REG_MASTER_ADDR:  cfg_in.master_address      = csr_data;
            mnhr_pkg::REG_MASTER_VIA:   cfg_in.master_via          = csr_data;
            mnhr_pkg::REG_MASTER_HOPS:  cfg_in.master_hops         = csr_data[7:0];
            mnhr_pkg::REG_HOP_LIMIT:    cfg_in.hop_limit           = csr_data[7:0];
            mnhr_pkg::REG_BEACON_CODE:  cfg_in.beacon_type_code    = csr_data[7:0];
            mnhr_pkg::REG_ADAPTER_CODE: cfg_in.adapter_data_code   = csr_data[7:0];
            mnhr_pkg::REG_SERIAL_CODE:  cfg_in.serial_payload_code = csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address         <= '0;
         cfg_ff.master_address      <= '0;
         cfg_ff.master_via          <= '0;
         cfg_ff.master_hops         <= mnhr_pkg::NO_ROUTE;
         cfg_ff.hop_limit           <= 8'd10;
         cfg_ff.beacon_type_code    <= 8'd0;
         cfg_ff.adapter_data_code   <= 8'd1;
         cfg_ff.serial_payload_code <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mnhr_front u_front (
      .start              (start),
      .busy               (busy),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_data             (push_data),
      .cfg                (cfg_ff),
      .req_opcode         (req_opcode),
      .req_hop_count      (req_hop_count),
      .req_msg_kind       (req_msg_kind),
      .req_payload_kind   (req_payload_kind),
      .req_origin_address (req_origin_address),
      .req_target_address (req_target_address),
      .req_entry_slot     (req_entry_slot),
      .req_entry_address  (req_entry_address),
      .req_entry_used     (req_entry_used)
   );

   mnhr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (head),
      .empty     (q_empty),
      .full      (q_full)
   );

   mnhr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_empty          (q_empty),
      .head             (head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_hop_present  (rsp_hop_present),
      .rsp_next_address (rsp_next_address),
      .rsp_distance     (rsp_distance),
      .rsp_final_res    (rsp_final_res)
   );

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// self-checking testbench for mesh_next_hop_router_core: directed and random beats,
// expected hops predicted in order and compared per field; depends on mnhr_pkg and the rtl
module tb;
   import mnhr_pkg::*;

   localparam logic OP_ROUTE = 1'b0;
   localparam logic OP_WRITE = 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED = 4'd15;
   localparam int SETTLE_CYCLES = 24;
   localparam int MAX_REPORTS = 10;

   typedef enum int {CFG_RANDOM, CFG_LOW, CFG_HIGH} cfg_mode_type;

   typedef struct {
      logic             opcode;
      logic [7:0]       hop_count;
      logic [7:0]       msg_kind;
      logic [7:0]       payload_kind;
      logic [MAC_W-1:0] origin;
      logic [MAC_W-1:0] target;
      logic [3:0]       entry_slot;
      logic [MAC_W-1:0] entry_address;
      logic             entry_used;
   } route_req_type;

   typedef struct {
      logic [2:0]       status;
      logic             hop_present;
      logic [MAC_W-1:0] next_address;
      logic [7:0]       distance;
      logic             final_res;
   } hop_result_type;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   logic             req_opcode;
   logic [7:0]       req_hop_count;
   logic [7:0]       req_msg_kind;
   logic [7:0]       req_payload_kind;
   logic [MAC_W-1:0] req_origin_address;
   logic [MAC_W-1:0] req_target_address;
   logic [3:0]       req_entry_slot;
   logic [MAC_W-1:0] req_entry_address;
   logic             req_entry_used;
   logic             rsp_valid;
   logic [2:0]       rsp_status;
   logic             rsp_hop_present;
   logic [MAC_W-1:0] rsp_next_address;
   logic [7:0]       rsp_distance;
   logic             rsp_final_res;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [MAC_W-1:0] csr_data;

   cfg_type          route_cfg;
   logic [MAC_W-1:0] nbr_mac [NEIGHBOR_SLOTS];
   logic             nbr_used [NEIGHBOR_SLOTS];
   hop_result_type   expected_hops [$];
   int               mismatches;
   int               idle_pct;

   mesh_next_hop_router_core u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_hop_count      (req_hop_count),
      .req_msg_kind       (req_msg_kind),
      .req_payload_kind   (req_payload_kind),
      .req_origin_address (req_origin_address),
      .req_target_address (req_target_address),
      .req_entry_slot     (req_entry_slot),
      .req_entry_address  (req_entry_address),
      .req_entry_used     (req_entry_used),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_hop_present    (rsp_hop_present),
      .rsp_next_address   (rsp_next_address),
      .rsp_distance       (rsp_distance),
      .rsp_final_res      (rsp_final_res),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

   function automatic logic [MAC_W-1:0] rand_mac();
      logic [63:0] v;
      v = {$urandom(), $urandom()};
      return v[MAC_W-1:0];
   endfunction

   function automatic logic [SLOT_IDX_W-1:0] rand_slot();
      return SLOT_IDX_W'($urandom_range(NEIGHBOR_SLOTS - 1));
   endfunction

   function automatic bit is_neighbor(input logic [MAC_W-1:0] mac);
      for (int i = 0; i < NEIGHBOR_SLOTS; i++)
         if (nbr_used[i] && nbr_mac[i] == mac) return 1'b1;
      return 1'b0;
   endfunction

   function automatic bit floods_to(input int i, input logic [MAC_W-1:0] origin);
      return nbr_used[i] && nbr_mac[i] != route_cfg.own_address && nbr_mac[i] != origin;
   endfunction

   function automatic void push_hop(input logic [2:0] status, input logic present,
                                    input logic [MAC_W-1:0] addr, input logic [7:0] hop_dist,
                                    input logic last);
      hop_result_type hr;
      hr.status       = status;
      hr.hop_present  = present;
      hr.next_address = addr;
      hr.distance     = hop_dist;
      hr.final_res    = last;
      expected_hops.insert(expected_hops.size(), hr);
   endfunction

   function automatic void forward_decision(input route_req_type r);
      int               eligible;
      int               n;
      logic [MAC_W-1:0] hop;
      logic [7:0]       hop_dist;
      bit               found;
      if (r.opcode == OP_WRITE) begin
         if (int'(r.entry_slot) < NEIGHBOR_SLOTS) begin
            nbr_mac[r.entry_slot]  = r.entry_address;
            nbr_used[r.entry_slot] = r.entry_used;
         end
         return;
      end
      if (r.hop_count >= route_cfg.hop_limit) begin
         push_hop(STAT_HOP_LIMIT, 1'b0, '0, 8'd0, 1'b1);
         return;
      end
      if (r.msg_kind == route_cfg.beacon_type_code ||
          r.payload_kind == route_cfg.serial_payload_code ||
          r.target[MAC_W-1:32] == BCAST_TOP) begin
         eligible = 0;
         for (int i = 0; i < NEIGHBOR_SLOTS; i++)
            if (floods_to(i, r.origin)) eligible++;
         if (eligible > RESULT_CAP) eligible = RESULT_CAP;
         if (eligible == 0) begin
            push_hop(STAT_OK, 1'b0, '0, 8'd1, 1'b1);
         end else begin
            n = 0;
            for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
               if (floods_to(i, r.origin) && n < eligible) begin
                  n++;
                  push_hop(STAT_OK, 1'b1, nbr_mac[i], 8'd1, n == eligible);
               end
            end
         end
         return;
      end
      if (r.msg_kind == route_cfg.adapter_data_code) begin
         if (route_cfg.master_hops != NO_ROUTE &&
             route_cfg.master_address != route_cfg.own_address)
            push_hop(STAT_OK, 1'b1, route_cfg.master_via, route_cfg.master_hops, 1'b1);
         else
            push_hop(STAT_NO_MASTER, 1'b0, '0, 8'd0, 1'b1);
         return;
      end
      if (r.target == '0 || r.target == MAC_ONES) begin
         push_hop(STAT_BAD_TGT, 1'b0, '0, 8'd0, 1'b1);
         return;
      end
      found = 1'b0;
      hop   = '0;
      if (r.target == route_cfg.master_address) begin
         if (route_cfg.master_hops != NO_ROUTE) begin
            found = 1'b1;
            hop   = route_cfg.master_via;
         end
      end else if (is_neighbor(r.target)) begin
         found = 1'b1;
         hop   = r.target;
      end else if (route_cfg.master_hops != NO_ROUTE) begin
         found = 1'b1;
         hop   = route_cfg.master_via;
      end
      if (!found) begin
         push_hop(STAT_NO_TARGET, 1'b0, '0, 8'd0, 1'b1);
         return;
      end
      if (r.target == route_cfg.own_address) hop_dist = 8'd0;
      else if (is_neighbor(r.target)) hop_dist = 8'd1;
      else hop_dist = 8'd2;
      push_hop(STAT_OK, 1'b1, hop, hop_dist, 1'b1);
   endfunction

   task automatic note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("%s", msg);
   endtask

   always @(posedge clock) begin
      hop_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (expected_hops.size() == 0) begin
            note_mismatch($sformatf("unexpected result beat: status %0d next %h",
                                    rsp_status, rsp_next_address));
         end else begin
            want = expected_hops.pop_front();
            if (rsp_status !== want.status || rsp_hop_present !== want.hop_present ||
                rsp_next_address !== want.next_address || rsp_distance !== want.distance ||
                rsp_final_res !== want.final_res)
               note_mismatch($sformatf(
                  {"mismatch: exp st %0d hp %0b nx %h d %0d f %0b, ",
                   "got st %0d hp %0b nx %h d %0d f %0b"},
                  want.status, want.hop_present, want.next_address, want.distance,
                  want.final_res, rsp_status, rsp_hop_present, rsp_next_address,
                  rsp_distance, rsp_final_res));
         end
      end
   end

   task automatic send_item(input route_req_type r);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_opcode         = r.opcode;
      req_hop_count      = r.hop_count;
      req_msg_kind       = r.msg_kind;
      req_payload_kind   = r.payload_kind;
      req_origin_address = r.origin;
      req_target_address = r.target;
      req_entry_slot     = r.entry_slot;
      req_entry_address  = r.entry_address;
      req_entry_used     = r.entry_used;
      start              = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      forward_decision(r);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      start = 1'b0;
      while (expected_hops.size() != 0) @(posedge clock);
   endtask

   task automatic quiesce();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [MAC_W-1:0] data);
      quiesce();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         REG_OWN_ADDR:     route_cfg.own_address         = data;
         REG_MASTER_ADDR:  route_cfg.master_address      = data;
         REG_MASTER_VIA:   route_cfg.master_via          = data;
         REG_MASTER_HOPS:  route_cfg.master_hops         = data[7:0];
         REG_HOP_LIMIT:    route_cfg.hop_limit           = data[7:0];
         REG_BEACON_CODE:  route_cfg.beacon_type_code    = data[7:0];
         REG_ADAPTER_CODE: route_cfg.adapter_data_code   = data[7:0];
         REG_SERIAL_CODE:  route_cfg.serial_payload_code = data[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // upper bits carry junk, only the low byte should stick
   task automatic write_byte_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      logic [MAC_W-1:0] junk;
      junk = rand_mac();
      write_reg(idx, {junk[MAC_W-1:8], val});
   endtask

   function automatic route_req_type make_route(input logic [7:0] hops,
                                                input logic [7:0] kind,
                                                input logic [7:0] pkind,
                                                input logic [MAC_W-1:0] origin,
                                                input logic [MAC_W-1:0] target);
      route_req_type r;
      r.opcode        = OP_ROUTE;
      r.hop_count     = hops;
      r.msg_kind      = kind;
      r.payload_kind  = pkind;
      r.origin        = origin;
      r.target        = target;
      r.entry_slot    = '0;
      r.entry_address = '0;
      r.entry_used    = 1'b0;
      return r;
   endfunction

   function automatic route_req_type make_entry(input logic [3:0] slot,
                                                input logic [MAC_W-1:0] mac,
                                                input logic used);
      route_req_type r;
      r = make_route(8'd0, 8'd0, 8'd0, '0, '0);
      r.opcode        = OP_WRITE;
      r.entry_slot    = slot;
      r.entry_address = mac;
      r.entry_used    = used;
      return r;
   endfunction

   function automatic route_req_type random_item();
      route_req_type r;
      int            pick;
      r.opcode = ($urandom_range(99) < 25) ? OP_WRITE : OP_ROUTE;
      if (route_cfg.hop_limit != 0 && $urandom_range(99) < 85)
         r.hop_count = 8'($urandom_range(int'(route_cfg.hop_limit) - 1));
      else
         r.hop_count = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 20) r.msg_kind = route_cfg.beacon_type_code;
      else if (pick < 45) r.msg_kind = route_cfg.adapter_data_code;
      else r.msg_kind = 8'($urandom_range(255));
      r.payload_kind = ($urandom_range(99) < 15) ? route_cfg.serial_payload_code
                                                 : 8'($urandom_range(255));
      r.origin = $urandom_range(1) ? nbr_mac[rand_slot()] : rand_mac();
      pick = $urandom_range(99);
      if (pick < 35) r.target = nbr_mac[rand_slot()];
      else if (pick < 45) r.target = route_cfg.own_address;
      else if (pick < 55) r.target = route_cfg.master_address;
      else if (pick < 63) r.target = {BCAST_TOP, 32'($urandom())};
      else if (pick < 67) r.target = '0;
      else if (pick < 70) r.target = MAC_ONES;
      else r.target = rand_mac();
      r.entry_slot = 4'($urandom_range(NEIGHBOR_SLOTS - 1));
      pick = $urandom_range(99);
      if (pick < 10) r.entry_address = route_cfg.own_address;
      else if (pick < 15) r.entry_address = route_cfg.master_address;
      else r.entry_address = rand_mac();
      r.entry_used = ($urandom_range(99) < 80);
      return r;
   endfunction

   task automatic apply_settings(input cfg_mode_type mode);
      logic [MAC_W-1:0] own;
      int               pick;
      case (mode)
         CFG_LOW: begin
            write_reg(REG_OWN_ADDR, '0);
            write_reg(REG_MASTER_ADDR, rand_mac());
            write_reg(REG_MASTER_VIA, '0);
            write_byte_reg(REG_MASTER_HOPS, 8'd0);
            write_byte_reg(REG_HOP_LIMIT, 8'd1);
            write_byte_reg(REG_BEACON_CODE, 8'd0);
            write_byte_reg(REG_ADAPTER_CODE, 8'd0);
            write_byte_reg(REG_SERIAL_CODE, 8'd0);
         end
         CFG_HIGH: begin
            write_reg(REG_OWN_ADDR, MAC_ONES);
            write_reg(REG_MASTER_ADDR, rand_mac());
            write_reg(REG_MASTER_VIA, MAC_ONES);
            write_byte_reg(REG_MASTER_HOPS, 8'd254);
            write_byte_reg(REG_HOP_LIMIT, 8'd255);
            write_byte_reg(REG_BEACON_CODE, 8'd255);
            write_byte_reg(REG_ADAPTER_CODE, 8'd255);
            write_byte_reg(REG_SERIAL_CODE, 8'd255);
         end
         default: begin
            own = $urandom_range(1) ? nbr_mac[rand_slot()] : rand_mac();
            write_reg(REG_OWN_ADDR, own);
            pick = $urandom_range(5);
            if (pick == 0) write_reg(REG_MASTER_ADDR, own);
            else if (pick < 3) write_reg(REG_MASTER_ADDR, nbr_mac[rand_slot()]);
            else write_reg(REG_MASTER_ADDR, rand_mac());
            write_reg(REG_MASTER_VIA, rand_mac());
            write_byte_reg(REG_MASTER_HOPS, ($urandom_range(3) == 0) ? NO_ROUTE
                                                                      : 8'($urandom_range(254)));
            write_byte_reg(REG_HOP_LIMIT, 8'($urandom_range(255, 2)));
            write_byte_reg(REG_BEACON_CODE, 8'($urandom_range(255)));
            write_byte_reg(REG_ADAPTER_CODE, 8'($urandom_range(255)));
            write_byte_reg(REG_SERIAL_CODE, 8'($urandom_range(255)));
         end
      endcase
   endtask

   localparam logic [MAC_W-1:0] OWN_MAC    = 48'h0200_0000_00A0;
   localparam logic [MAC_W-1:0] MASTER_MAC = 48'h0200_0000_00B0;
   localparam logic [MAC_W-1:0] VIA_MAC    = 48'h0200_0000_00C0;
   localparam logic [MAC_W-1:0] PEER0_MAC  = 48'h0200_0000_0001;
   localparam logic [MAC_W-1:0] PEER2_MAC  = 48'h0200_0000_0002;
   localparam logic [MAC_W-1:0] PEER7_MAC  = 48'h0200_0000_0007;
   localparam logic [MAC_W-1:0] STRAY_MAC  = 48'h0012_3456_789A;

   task automatic test_reset_state();
      send_item(make_route(8'd0, 8'h05, 8'h05, rand_mac(), STRAY_MAC));
      send_item(make_route(8'd0, 8'h00, 8'h05, rand_mac(), STRAY_MAC));
      send_item(make_route(8'd0, 8'h01, 8'h05, rand_mac(), STRAY_MAC));
   endtask

   task automatic test_config_regs();
      write_reg(REG_OWN_ADDR, OWN_MAC);
      write_reg(REG_MASTER_ADDR, MASTER_MAC);
      write_reg(REG_MASTER_VIA, VIA_MAC);
      write_byte_reg(REG_MASTER_HOPS, 8'd3);
      write_byte_reg(REG_HOP_LIMIT, 8'd10);
      write_byte_reg(REG_BEACON_CODE, 8'h55);
      write_byte_reg(REG_ADAPTER_CODE, 8'h66);
      write_byte_reg(REG_SERIAL_CODE, 8'h77);
      write_reg(REG_UNMAPPED, MAC_ONES);
   endtask

   task automatic test_table_writes();
      send_item(make_entry(4'd0, PEER0_MAC, 1'b1));
      send_item(make_entry(4'd1, OWN_MAC, 1'b1));
      send_item(make_entry(4'd2, PEER2_MAC, 1'b0));
      send_item(make_entry(4'd3, '0, 1'b1));
      send_item(make_entry(4'd7, PEER7_MAC, 1'b1));
      send_item(make_entry(4'd15, MAC_ONES, 1'b1));
   endtask

   task automatic test_hop_limit();
      send_item(make_route(8'd255, 8'h10, 8'h10, STRAY_MAC, PEER0_MAC));
      send_item(make_route(8'd10, 8'h10, 8'h10, STRAY_MAC, PEER0_MAC));
      write_byte_reg(REG_HOP_LIMIT, 8'd0);
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, PEER0_MAC));
      write_byte_reg(REG_HOP_LIMIT, 8'd10);
   endtask

   task automatic test_broadcast();
      send_item(make_route(8'd9, 8'h55, 8'h10, PEER0_MAC, STRAY_MAC));
      send_item(make_route(8'd0, 8'h10, 8'h77, STRAY_MAC, STRAY_MAC));
      send_item(make_route(8'd1, 8'h10, 8'h10, MAC_ONES, {BCAST_TOP, 32'h1234_5678}));
   endtask

   task automatic test_adapter();
      send_item(make_route(8'd0, 8'h66, 8'h10, STRAY_MAC, STRAY_MAC));
      write_reg(REG_MASTER_ADDR, OWN_MAC);
      send_item(make_route(8'd0, 8'h66, 8'h10, STRAY_MAC, STRAY_MAC));
      write_reg(REG_MASTER_ADDR, MASTER_MAC);
   endtask

   task automatic test_targets();
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, '0));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, MAC_ONES));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, MASTER_MAC));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, PEER0_MAC));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, OWN_MAC));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, STRAY_MAC));
      write_byte_reg(REG_MASTER_HOPS, NO_ROUTE);
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, PEER7_MAC));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, STRAY_MAC));
      send_item(make_route(8'd0, 8'h10, 8'h10, STRAY_MAC, MASTER_MAC));
   endtask

   task automatic test_random();
      cfg_mode_type modes [6] = '{CFG_RANDOM, CFG_HIGH, CFG_RANDOM, CFG_LOW,
                                  CFG_RANDOM, CFG_RANDOM};
      int           idles [6] = '{0, 51, 33, 0, 51, 33};
      int           counts [6] = '{70, 60, 60, 40, 60, 60};
      for (int p = 0; p < 6; p++) begin
         apply_settings(modes[p]);
         idle_pct = idles[p];
         for (int k = 0; k < counts[p]; k++) begin
            if (k == counts[p] / 2 || $urandom_range(199) == 0) wait_for_results();
            send_item(random_item());
         end
      end
      idle_pct = 0;
   endtask

   initial begin
      reset              = 1'b1;
      start              = 1'b0;
      req_opcode         = OP_ROUTE;
      req_hop_count      = '0;
      req_msg_kind       = '0;
      req_payload_kind   = '0;
      req_origin_address = '0;
      req_target_address = '0;
      req_entry_slot     = '0;
      req_entry_address  = '0;
      req_entry_used     = 1'b0;
      csr_valid          = 1'b0;
      csr_index          = '0;
      csr_data           = '0;
      mismatches         = 0;
      idle_pct           = 0;
      route_cfg.own_address         = '0;
      route_cfg.master_address      = '0;
      route_cfg.master_via          = '0;
      route_cfg.master_hops         = 8'd255;
      route_cfg.hop_limit           = 8'd10;
      route_cfg.beacon_type_code    = 8'd0;
      route_cfg.adapter_data_code   = 8'd1;
      route_cfg.serial_payload_code = 8'd0;
      for (int i = 0; i < NEIGHBOR_SLOTS; i++) begin
         nbr_mac[i]  = '0;
         nbr_used[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      repeat (4) @(posedge clock);

      test_reset_state();
      test_config_regs();
      test_table_writes();
      test_hop_limit();
      test_broadcast();
      test_adapter();
      test_targets();
      test_random();

      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_hops.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
